FILE: hw/rtl/vrq_pkg.sv
// Shared constants and codes for the variable-length record ring queue.
// No dependencies; used by vrq_ram users and the top level.
package vrq_pkg;

    // Ring size must be a power of two: pointers wrap by natural overflow.
    localparam int BUF_BYTES    = 256;
    localparam int PTR_W        = $clog2(BUF_BYTES);
    localparam int SPACE_W      = $clog2(BUF_BYTES + 1);
    localparam int MAX_LEN      = 60;
    localparam int LEN_W        = 6;
    localparam int HEADER_BYTES = 4;
    localparam int HCNT_W       = $clog2(HEADER_BYTES + 1);
    localparam int BYTE_W       = 8;

    localparam int S_TDATA_W    = 16;
    localparam int M_TDATA_W    = 24;
    localparam int M_TUSER_W    = 3;

    typedef enum logic [1:0] {
        OP_PUSH_BEGIN = 2'd0,
        OP_PUSH_BYTE  = 2'd1,
        OP_POP        = 2'd2,
        OP_CLEAR      = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_EMPTY  = 2'd2,
        STAT_NOPEND = 2'd3
    } status_t;

endpackage

FILE: hw/rtl/vrq_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module vrq_ram #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8,
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/variable_record_ring_queue.sv
// Top level of the variable-length record ring queue: control, pointers, output register.
// Depends on vrq_pkg and vrq_ram.
//
//  channel  direction  tdata fields (low bit up)                 tuser / tlast
//  s_       in         op[1:0] length[7:2] byte_in[15:8]          -
//  m_       out        data_out[7:0] free_bytes[16:8] (pad 0)     status[1:0] data_valid[2] / last
//
// push_byte, clear and any refused op complete in ST_IDLE. push_begin: ST_IDLE, then ST_HDR, one
// header byte per cycle through the single RAM write port. pop: ST_IDLE issues the header read,
// ST_POP_HDR takes the header, then ST_POP_DATA issues the data reads and emits the bytes back
// to back through the registered RAM read port (a pop that emits nothing gives one status beat).
// Reset (aresetn low, synchronous) empties the queue at once; the store is not cleared.
// A stalled m_tready holds the output register and pauses the pop byte stream.
module variable_record_ring_queue (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [vrq_pkg::S_TDATA_W-1:0]  s_tdata,  // op, length, byte_in
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [vrq_pkg::M_TDATA_W-1:0]  m_tdata,  // data_out, free_bytes, zero pad
    output logic [vrq_pkg::M_TUSER_W-1:0]  m_tuser,  // status, data_valid
    output logic                           m_tlast
);

    localparam int PTR_W   = vrq_pkg::PTR_W;
    localparam int SPACE_W = vrq_pkg::SPACE_W;
    localparam int LEN_W   = vrq_pkg::LEN_W;
    localparam int HCNT_W  = vrq_pkg::HCNT_W;
    localparam int BYTE_W  = vrq_pkg::BYTE_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HDR,
        ST_POP_HDR,
        ST_POP_DATA
    } state_t;

    state_t                state_reg, state_next;
    logic [PTR_W-1:0]      head_reg, head_next;
    logic [PTR_W-1:0]      tail_reg, tail_next;
    logic [SPACE_W-1:0]    space_reg, space_next;
    logic [LEN_W-1:0]      push_rem_reg, push_rem_next;
    logic [HCNT_W-1:0]     hcnt_reg, hcnt_next;
    logic [LEN_W-1:0]      len_reg, len_next;
    logic [LEN_W-1:0]      take_reg, take_next;
    logic [LEN_W-1:0]      iss_cnt_reg, iss_cnt_next;
    logic [LEN_W-1:0]      out_cnt_reg, out_cnt_next;
    logic [PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic                  pend_reg, pend_next;

    logic                  m_tvalid_reg, m_tvalid_next;
    vrq_pkg::status_t      status_reg, status_next;
    logic [BYTE_W-1:0]     dout_reg, dout_next;
    logic                  dvalid_reg, dvalid_next;
    logic                  last_reg, last_next;
    logic [SPACE_W-1:0]    free_reg, free_next;

    logic                  wr_en;
    logic [BYTE_W-1:0]     wr_data;
    logic                  rd_en;
    logic [PTR_W-1:0]      rd_addr;
    logic [BYTE_W-1:0]     rd_data;

    logic                  out_free;
    logic                  accept;
    vrq_pkg::op_t          in_op;
    logic [LEN_W-1:0]      in_len;
    logic [BYTE_W-1:0]     in_byte;
    logic [SPACE_W-1:0]    need;

    logic [SPACE_W-1:0]    used;
    logic [SPACE_W-1:0]    room;
    logic [SPACE_W-1:0]    hdr_val;
    logic [SPACE_W-1:0]    hdr_cut;
    logic [SPACE_W:0]      space_sum;
    logic [SPACE_W-1:0]    take_a;
    logic [SPACE_W-1:0]    take_b;
    logic                  load;
    logic                  issue;

    vrq_ram #(
        .DEPTH  (vrq_pkg::BUF_BYTES),
        .ADDR_W (PTR_W),
        .DATA_W (BYTE_W)
    ) u_ram (
        .clk     (aclk),
        .wr_en   (wr_en),
        .wr_addr (tail_reg),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    assign in_op   = vrq_pkg::op_t'(s_tdata[1:0]);
    assign in_len  = s_tdata[7:2];
    assign in_byte = s_tdata[15:8];
    assign need    = SPACE_W'(in_len) + SPACE_W'(vrq_pkg::HEADER_BYTES);

    // Header fetch: limit the length to the bytes actually held, then to the requested length, then to MAX_LEN.
    assign used      = SPACE_W'(vrq_pkg::BUF_BYTES) - space_reg;
    assign room      = (used >= SPACE_W'(vrq_pkg::HEADER_BYTES))
                       ? used - SPACE_W'(vrq_pkg::HEADER_BYTES) : '0;
    assign hdr_val   = SPACE_W'(rd_data);
    assign hdr_cut   = (hdr_val > room) ? room : hdr_val;
    assign space_sum = (SPACE_W + 1)'(space_reg) + (SPACE_W + 1)'(hdr_cut)
                       + (SPACE_W + 1)'(vrq_pkg::HEADER_BYTES);
    assign take_a    = (hdr_cut < SPACE_W'(len_reg)) ? hdr_cut : SPACE_W'(len_reg);
    assign take_b    = (take_a > SPACE_W'(vrq_pkg::MAX_LEN))
                       ? SPACE_W'(vrq_pkg::MAX_LEN) : take_a;

    assign load  = (state_reg == ST_POP_DATA) && pend_reg && out_free;
    assign issue = (state_reg == ST_POP_DATA) && (iss_cnt_reg != take_reg)
                   && (!pend_reg || load);

    always_comb begin
        state_next    = state_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        space_next    = space_reg;
        push_rem_next = push_rem_reg;
        hcnt_next     = hcnt_reg;
        len_next      = len_reg;
        take_next     = take_reg;
        iss_cnt_next  = iss_cnt_reg;
        out_cnt_next  = out_cnt_reg;
        rd_ptr_next   = rd_ptr_reg;
        pend_next     = pend_reg;
        wr_en         = 1'b0;
        wr_data       = '0;
        rd_en         = 1'b0;
        rd_addr       = head_reg;

        m_tvalid_next = m_tready ? 1'b0 : m_tvalid_reg;
        status_next   = status_reg;
        dout_next     = dout_reg;
        dvalid_next   = dvalid_reg;
        last_next     = last_reg;
        free_next     = free_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    m_tvalid_next = 1'b1;
                    status_next   = vrq_pkg::STAT_OK;
                    dout_next     = '0;
                    dvalid_next   = 1'b0;
                    last_next     = 1'b1;
                    unique case (in_op)
                        vrq_pkg::OP_PUSH_BEGIN: begin
                            if (push_rem_reg != '0 || in_len > LEN_W'(vrq_pkg::MAX_LEN)
                                || space_reg < need) begin
                                status_next = vrq_pkg::STAT_FULL;
                            end else begin
                                space_next    = space_reg - need;
                                wr_en         = 1'b1;
                                wr_data       = BYTE_W'(in_len);
                                tail_next     = tail_reg + PTR_W'(1);
                                push_rem_next = in_len;
                                if (vrq_pkg::HEADER_BYTES > 1) begin
                                    hcnt_next  = HCNT_W'(vrq_pkg::HEADER_BYTES - 1);
                                    state_next = ST_HDR;
                                end
                            end
                        end
                        vrq_pkg::OP_PUSH_BYTE: begin
                            if (push_rem_reg == '0) begin
                                status_next = vrq_pkg::STAT_NOPEND;
                            end else begin
                                wr_en         = 1'b1;
                                wr_data       = in_byte;
                                tail_next     = tail_reg + PTR_W'(1);
                                push_rem_next = push_rem_reg - LEN_W'(1);
                            end
                        end
                        vrq_pkg::OP_POP: begin
                            if (push_rem_reg != '0
                                || space_reg >= SPACE_W'(vrq_pkg::BUF_BYTES)) begin
                                status_next = vrq_pkg::STAT_EMPTY;
                            end else begin
                                m_tvalid_next = m_tready ? 1'b0 : m_tvalid_reg;
                                status_next   = status_reg;
                                dout_next     = dout_reg;
                                dvalid_next   = dvalid_reg;
                                last_next     = last_reg;
                                rd_en         = 1'b1;
                                head_next     = head_reg + PTR_W'(vrq_pkg::HEADER_BYTES);
                                len_next      = in_len;
                                state_next    = ST_POP_HDR;
                            end
                        end
                        vrq_pkg::OP_CLEAR: begin
                            space_next    = SPACE_W'(vrq_pkg::BUF_BYTES);
                            tail_next     = head_reg;
                            push_rem_next = '0;
                        end
                    endcase
                    free_next = space_next;
                end
            end
            ST_HDR: begin
                wr_en     = 1'b1;
                tail_next = tail_reg + PTR_W'(1);
                hcnt_next = hcnt_reg - HCNT_W'(1);
                if (hcnt_reg == HCNT_W'(1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_POP_HDR: begin
                space_next   = (space_sum > (SPACE_W + 1)'(vrq_pkg::BUF_BYTES))
                               ? SPACE_W'(vrq_pkg::BUF_BYTES) : space_sum[SPACE_W-1:0];
                head_next    = head_reg + hdr_cut[PTR_W-1:0];
                rd_ptr_next  = head_reg;
                take_next    = take_b[LEN_W-1:0];
                iss_cnt_next = '0;
                out_cnt_next = '0;
                pend_next    = 1'b0;
                state_next   = ST_POP_DATA;
            end
            ST_POP_DATA: begin
                if (take_reg == '0) begin
                    if (out_free) begin
                        m_tvalid_next = 1'b1;
                        status_next   = vrq_pkg::STAT_OK;
                        dout_next     = '0;
                        dvalid_next   = 1'b0;
                        last_next     = 1'b1;
                        free_next     = space_reg;
                        state_next    = ST_IDLE;
                    end
                end else begin
                    if (load) begin
                        m_tvalid_next = 1'b1;
                        status_next   = vrq_pkg::STAT_OK;
                        dout_next     = rd_data;
                        dvalid_next   = 1'b1;
                        last_next     = (out_cnt_reg == take_reg - LEN_W'(1));
                        free_next     = space_reg;
                        out_cnt_next  = out_cnt_reg + LEN_W'(1);
                        if (out_cnt_reg == take_reg - LEN_W'(1)) begin
                            state_next = ST_IDLE;
                        end
                    end
                    if (issue) begin
                        rd_en        = 1'b1;
                        rd_addr      = rd_ptr_reg;
                        rd_ptr_next  = rd_ptr_reg + PTR_W'(1);
                        iss_cnt_next = iss_cnt_reg + LEN_W'(1);
                    end
                    pend_next = issue || (pend_reg && !load);
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            space_reg    <= SPACE_W'(vrq_pkg::BUF_BYTES);
            push_rem_reg <= '0;
            hcnt_reg     <= '0;
            len_reg      <= '0;
            take_reg     <= '0;
            iss_cnt_reg  <= '0;
            out_cnt_reg  <= '0;
            rd_ptr_reg   <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            status_reg   <= vrq_pkg::STAT_OK;
            dout_reg     <= '0;
            dvalid_reg   <= 1'b0;
            last_reg     <= 1'b0;
            free_reg     <= '0;
        end else begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            space_reg    <= space_next;
            push_rem_reg <= push_rem_next;
            hcnt_reg     <= hcnt_next;
            len_reg      <= len_next;
            take_reg     <= take_next;
            iss_cnt_reg  <= iss_cnt_next;
            out_cnt_reg  <= out_cnt_next;
            rd_ptr_reg   <= rd_ptr_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
            status_reg   <= status_next;
            dout_reg     <= dout_next;
            dvalid_reg   <= dvalid_next;
            last_reg     <= last_next;
            free_reg     <= free_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(vrq_pkg::M_TDATA_W - SPACE_W - BYTE_W)'(0), free_reg, dout_reg};
    assign m_tuser  = {dvalid_reg, status_reg};
    assign m_tlast  = last_reg;

endmodule
